>>> rtl/dssm_pkg.sv
// shared types and constants for the dual stack shared memory unit
package dssm_pkg;

  localparam int unsigned DEPTH      = 256;
  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned AW         = $clog2(DEPTH);
  localparam int unsigned CW         = $clog2(DEPTH + 1);
  localparam int unsigned CAP_W      = 9;
  localparam int unsigned KIND_W     = 3;
  localparam int unsigned STATUS_W   = 2;

  localparam logic [KIND_W-1:0] KIND_PUSH     = 3'd0;
  localparam logic [KIND_W-1:0] KIND_POP      = 3'd1;
  localparam logic [KIND_W-1:0] KIND_PEEK     = 3'd2;
  localparam logic [KIND_W-1:0] KIND_PEEK_POP = 3'd3;
  localparam logic [KIND_W-1:0] KIND_CLEAR    = 3'd4;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

  localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

  typedef struct packed {
    logic exec;
    logic respond;
    logic cfg_wr;
  } dssm_cmd_t;

endpackage

>>> rtl/dssm_ctrl.sv
// controller state machine: item acceptance, response strobe and config gating
module dssm_ctrl
  import dssm_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  logic      cfg_valid_i,
  output logic      busy_o,
  output logic      cfg_ready_o,
  output dssm_cmd_t cmd_o
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_RESP = 1'b1;

  logic state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) state_d = S_RESP;
      end
      S_RESP: begin
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o       = (state_q == S_RESP);
  // an item at start takes the cycle ahead of a config write
  assign cfg_ready_o  = (state_q == S_IDLE) && !start_i;
  assign cmd_o.exec    = (state_q == S_IDLE) && start_i;
  assign cmd_o.respond = (state_q == S_RESP);
  assign cmd_o.cfg_wr  = cfg_ready_o && cfg_valid_i;

endmodule

>>> rtl/dssm_dp.sv
// datapath: element memory, stack counts, capacity register and result registers
module dssm_dp
  import dssm_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  dssm_cmd_t             cmd_i,
  input  logic [KIND_W-1:0]     kind_i,
  input  logic                  which_stack_i,
  input  logic [DATA_WIDTH-1:0] push_value_i,
  input  logic [CAP_W-1:0]      cfg_data_i,
  output logic [DATA_WIDTH-1:0] read_value_o,
  output logic [STATUS_W-1:0]   status_o,
  output logic                  first_empty_o,
  output logic                  second_empty_o,
  output logic                  store_full_o
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  logic [CAP_W-1:0]      cap_q;
  logic [CW-1:0]         first_q, first_d;
  logic [CW-1:0]         second_q, second_d;
  logic [STATUS_W-1:0]   status_q, status_d;
  logic                  rd_en_q;
  logic [DATA_WIDTH-1:0] rdata_q;

  logic [CW-1:0] cap_eff;
  logic [CW:0]   used;
  logic          full;
  logic [CW-1:0] cnt;
  logic          empty_sel;
  logic [AW-1:0] push_addr;
  logic [AW-1:0] top_addr;
  logic          wr_en;
  logic          rd_en;

  assign cap_eff = (cap_q > CAP_W'(DEPTH)) ? CW'(DEPTH) : CW'(cap_q);
  assign used    = {1'b0, first_q} + {1'b0, second_q};
  assign full    = used >= {1'b0, cap_eff};
  assign cnt     = which_stack_i ? second_q : first_q;
  assign empty_sel = (cnt == '0);

  // stack two grows down from the capacity, addresses wrap on the memory depth
  always_comb begin
    logic [CW-1:0] dn_push, dn_top, up_top;
    dn_push = cap_eff - second_q - CW'(1);
    dn_top  = cap_eff - second_q;
    up_top  = first_q - CW'(1);
    push_addr = which_stack_i ? dn_push[AW-1:0] : first_q[AW-1:0];
    top_addr  = which_stack_i ? dn_top[AW-1:0]  : up_top[AW-1:0];
  end

  always_comb begin
    first_d  = first_q;
    second_d = second_q;
    status_d = STATUS_OK;
    wr_en    = 1'b0;
    rd_en    = 1'b0;
    case (kind_i) inside
      KIND_PUSH: begin
        if (full) begin
          status_d = STATUS_FULL;
        end else begin
          wr_en = 1'b1;
          if (which_stack_i) second_d = second_q + CW'(1);
          else               first_d  = first_q + CW'(1);
        end
      end
      KIND_POP, KIND_PEEK, KIND_PEEK_POP: begin
        if (empty_sel) begin
          status_d = STATUS_EMPTY;
        end else begin
          rd_en = (kind_i != KIND_POP);
          if (kind_i != KIND_PEEK) begin
            if (which_stack_i) second_d = second_q - CW'(1);
            else               first_d  = first_q - CW'(1);
          end
        end
      end
      KIND_CLEAR: begin
        if (which_stack_i) second_d = '0;
        else               first_d  = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q    <= CAP_RESET;
      first_q  <= '0;
      second_q <= '0;
      status_q <= STATUS_OK;
      rd_en_q  <= 1'b0;
    end else if (cmd_i.cfg_wr) begin
      // a new capacity starts both stacks empty
      cap_q    <= cfg_data_i;
      first_q  <= '0;
      second_q <= '0;
    end else if (cmd_i.exec) begin
      first_q  <= first_d;
      second_q <= second_d;
      status_q <= status_d;
      rd_en_q  <= rd_en;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && !cmd_i.cfg_wr && wr_en) mem[push_addr] <= push_value_i;
    if (cmd_i.exec && rd_en) rdata_q <= mem[top_addr];
  end

  assign read_value_o   = rd_en_q ? rdata_q : '0;
  assign status_o       = status_q;
  assign first_empty_o  = (first_q == '0);
  assign second_empty_o = (second_q == '0);
  assign store_full_o   = full;

endmodule

>>> rtl/dual_stack_shared_memory_unit.sv
// top level of the dual stack shared memory unit
//
// channel   direction  handshake                     payload
// command   in         start_i, busy_o               kind_i, which_stack_i, push_value_i
// result    out        done_o (one-cycle strobe)     read_value_o, status_o, first_empty_o,
//                                                    second_empty_o, store_full_o
// config    in         cfg_valid_i, cfg_ready_o      cfg_data_i (capacity in use)
//
// for an item, the accepting edge does the memory access and the count
// update, the next cycle shows the result with done_o high while busy_o is high.
// the memory read is registered, and the response state holds busy_o, so no new item is taken then.
// reset clears the counts and loads a capacity of 256; memory contents are not cleared.
// results cannot be stalled; config writes are taken while busy_o and start_i are low.
module dual_stack_shared_memory_unit
  import dssm_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic [KIND_W-1:0]     kind_i,
  input  logic                  which_stack_i,
  input  logic [DATA_WIDTH-1:0] push_value_i,
  output logic                  done_o,
  output logic [DATA_WIDTH-1:0] read_value_o,
  output logic [STATUS_W-1:0]   status_o,
  output logic                  first_empty_o,
  output logic                  second_empty_o,
  output logic                  store_full_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CAP_W-1:0]      cfg_data_i
);

  dssm_cmd_t cmd;

  dssm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .cfg_valid_i (cfg_valid_i),
    .busy_o      (busy_o),
    .cfg_ready_o (cfg_ready_o),
    .cmd_o       (cmd)
  );

  dssm_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .kind_i         (kind_i),
    .which_stack_i  (which_stack_i),
    .push_value_i   (push_value_i),
    .cfg_data_i     (cfg_data_i),
    .read_value_o   (read_value_o),
    .status_o       (status_o),
    .first_empty_o  (first_empty_o),
    .second_empty_o (second_empty_o),
    .store_full_o   (store_full_o)
  );

  assign done_o = cmd.respond;

endmodule
